// ===== design/local_maxima_run_detector_top_macros.svh =====
// Assertion shorthands shared by the detector RTL.
`ifndef LOCAL_MAXIMA_RUN_DETECTOR_TOP_MACROS_SVH
`define LOCAL_MAXIMA_RUN_DETECTOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LMRD_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("lmrd: same-cycle check failed");
// next-cycle implication
`define LMRD_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("lmrd: next-cycle check failed");
`else
`define LMRD_ASSERT_IMP(label, clk, rst_n, lhs, rhs)
`define LMRD_ASSERT_NXT(label, clk, rst_n, lhs, rhs)
`endif

`endif

// ===== design/lmrd_pkg.sv =====
`timescale 1ns / 1ps

package lmrd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int POS_W    = 17;
    localparam int WIDTH_W  = 16;
    localparam int COUNT_W  = 16;

    // longest vector the position counters handle
    localparam logic [POS_W-1:0] MAX_LEN = POS_W'(65536);

    // register indexes; byte address is index * 4
    localparam logic [2:0] REG_MIN_WIDTH = 3'd0;
    localparam logic [2:0] REG_MAX_PEAKS = 3'd1;
    localparam logic [2:0] REG_SCAN_END  = 3'd2;
    localparam logic [2:0] REG_EDGE_OK   = 3'd3;
    localparam logic [2:0] REG_SEQ_LEN   = 3'd4;

    typedef enum logic [1:0] {
        DIR_FLAT = 2'd0,
        DIR_RISE = 2'd1,
        DIR_FALL = 2'd2,
        DIR_NONE = 2'd3
    } dir_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_sample;
    } lmrd_in_t;

    typedef struct packed {
        logic        [POS_W-1:0]    peak_position;
        logic signed [SAMPLE_W-1:0] peak_value;
        logic        [POS_W-1:0]    peak_number;
    } lmrd_out_t;

    typedef struct packed {
        logic [WIDTH_W-1:0] min_width;
        logic [COUNT_W-1:0] max_peaks;
        logic               scan_from_end;
        logic               edge_ok;
        logic [POS_W-1:0]   seq_length;
    } lmrd_cfg_t;

endpackage

// ===== design/lmrd_regs.sv =====
`timescale 1ns / 1ps

module lmrd_regs
    import lmrd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output lmrd_cfg_t   cfg
);

    lmrd_cfg_t  cfg_reg;
    lmrd_cfg_t  cfg_next;
    logic [2:0] index;
    logic       wr_en;

    assign index  = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (index)
                REG_MIN_WIDTH: cfg_next.min_width     = pwdata[WIDTH_W-1:0];
                REG_MAX_PEAKS: cfg_next.max_peaks     = pwdata[COUNT_W-1:0];
                REG_SCAN_END:  cfg_next.scan_from_end = pwdata[0];
                REG_EDGE_OK:   cfg_next.edge_ok       = pwdata[0];
                REG_SEQ_LEN:   cfg_next.seq_length    = pwdata[POS_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_MIN_WIDTH: prdata = 32'(cfg_reg.min_width);
            REG_MAX_PEAKS: prdata = 32'(cfg_reg.max_peaks);
            REG_SCAN_END:  prdata = 32'(cfg_reg.scan_from_end);
            REG_EDGE_OK:   prdata = 32'(cfg_reg.edge_ok);
            REG_SEQ_LEN:   prdata = 32'(cfg_reg.seq_length);
            default:       prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_width     <= WIDTH_W'(1);
            cfg_reg.max_peaks     <= '0;
            cfg_reg.scan_from_end <= 1'b0;
            cfg_reg.edge_ok       <= 1'b0;
            cfg_reg.seq_length    <= MAX_LEN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== design/lmrd_core.sv =====
`timescale 1ns / 1ps
`include "local_maxima_run_detector_top_macros.svh"

module lmrd_core
    import lmrd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  lmrd_in_t  item,
    input  lmrd_cfg_t cfg,
    output logic      found,
    output lmrd_out_t result
);

    logic signed [SAMPLE_W-1:0] prior_reg, prior_next;
    logic [POS_W-1:0]           pos_reg, pos_next;
    dir_t                       dir_reg, dir_next;
    logic [POS_W-1:0]           run_len_reg, run_len_next;
    logic [POS_W-1:0]           prev_run_reg, prev_run_next;
    logic [POS_W-1:0]           sw_pos_reg, sw_pos_next;
    logic signed [SAMPLE_W-1:0] sw_val_reg, sw_val_next;
    logic [1:0]                 changes_reg, changes_next;
    logic [POS_W-1:0]           peaks_reg, peaks_next;
    logic [POS_W-1:0]           last_rep_reg, last_rep_next;
    logic                       stopped_reg, stopped_next;

    logic [POS_W-1:0] len;
    logic [POS_W-1:0] pos_n;
    logic [POS_W:0]   here_bwd;
    logic [POS_W:0]   next_bwd;
    logic [POS_W-1:0] here;
    logic [POS_W-1:0] next_pos;
    logic             backward;
    logic             at_end;
    logic             active;
    logic             falling;
    logic [POS_W-1:0] width_ext;
    dir_t             dir;

    always_comb
    begin
        len       = (cfg.seq_length > MAX_LEN) ? MAX_LEN : cfg.seq_length;
        pos_n     = pos_reg + 1'b1;
        at_end    = item.last_sample || (pos_n >= len);
        backward  = (cfg.max_peaks != '0) && cfg.scan_from_end;
        here_bwd  = {1'b0, len} + (POS_W+1)'(2) - {1'b0, pos_n};
        next_bwd  = {1'b0, len} + (POS_W+1)'(1) - {1'b0, pos_n};
        here      = backward ? here_bwd[POS_W-1:0] : (pos_n - 1'b1);
        next_pos  = backward ? next_bwd[POS_W-1:0] : pos_n;
        width_ext = POS_W'(cfg.min_width);
        active    = !stopped_reg && (pos_n >= POS_W'(2));

        if (item.sample > prior_reg)
            dir = DIR_RISE;
        else if (item.sample < prior_reg)
            dir = DIR_FALL;
        else
            dir = DIR_FLAT;
        falling = (dir == DIR_FALL);

        prior_next    = item.sample;
        pos_next      = pos_n;
        dir_next      = dir_reg;
        run_len_next  = run_len_reg;
        prev_run_next = prev_run_reg;
        sw_pos_next   = sw_pos_reg;
        sw_val_next   = sw_val_reg;
        changes_next  = changes_reg;
        peaks_next    = peaks_reg;
        last_rep_next = last_rep_reg;
        stopped_next  = stopped_reg;
        found         = 1'b0;
        result        = '0;

        if (active)
        begin
            if (dir == dir_reg)
            begin
                run_len_next = run_len_reg + 1'b1;
            end
            else
            begin
                dir_next      = dir;
                prev_run_next = run_len_reg;
                run_len_next  = POS_W'(1);
                sw_pos_next   = here;
                sw_val_next   = prior_reg;
                if (changes_reg != 2'd3)
                    changes_next = changes_reg + 1'b1;
            end

            found = falling && (prev_run_next >= width_ext) && (run_len_next == width_ext);
            if (cfg.edge_ok)
            begin
                // peak cut off at the start of the vector
                if (falling && (changes_next != 2'd3) && (run_len_next == width_ext))
                    found = 1'b1;
                // peak cut off at, or sitting on, the end of the vector
                if (at_end && ((falling && (prev_run_next >= width_ext)) ||
                               (!falling && (run_len_next >= width_ext))))
                    found = 1'b1;
                if (found && !falling)
                begin
                    sw_pos_next = next_pos;
                    sw_val_next = item.sample;
                end
                // drop a repeat of the previous report
                if (found && (peaks_reg != '0) && (last_rep_reg == sw_pos_next))
                    found = 1'b0;
            end

            if (found)
            begin
                peaks_next           = peaks_reg + 1'b1;
                last_rep_next        = sw_pos_next;
                result.peak_position = sw_pos_next;
                result.peak_value    = sw_val_next;
                result.peak_number   = peaks_next;
                if ((cfg.max_peaks != '0) && (peaks_next == POS_W'(cfg.max_peaks)))
                    stopped_next = 1'b1;
            end
        end

        if (at_end)
        begin
            prior_next    = '0;
            pos_next      = '0;
            dir_next      = DIR_NONE;
            run_len_next  = '0;
            prev_run_next = '0;
            sw_pos_next   = '0;
            sw_val_next   = '0;
            changes_next  = '0;
            peaks_next    = '0;
            last_rep_next = '0;
            stopped_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_reg    <= '0;
            pos_reg      <= '0;
            dir_reg      <= DIR_NONE;
            run_len_reg  <= '0;
            prev_run_reg <= '0;
            sw_pos_reg   <= '0;
            sw_val_reg   <= '0;
            changes_reg  <= '0;
            peaks_reg    <= '0;
            last_rep_reg <= '0;
            stopped_reg  <= 1'b0;
        end
        else if (step)
        begin
            prior_reg    <= prior_next;
            pos_reg      <= pos_next;
            dir_reg      <= dir_next;
            run_len_reg  <= run_len_next;
            prev_run_reg <= prev_run_next;
            sw_pos_reg   <= sw_pos_next;
            sw_val_reg   <= sw_val_next;
            changes_reg  <= changes_next;
            peaks_reg    <= peaks_next;
            last_rep_reg <= last_rep_next;
            stopped_reg  <= stopped_next;
        end
    end

    // a run exists exactly when at least one direction has been seen
    `LMRD_ASSERT_IMP(a_run_vs_changes, clk, rst_n, changes_reg == 2'd0, run_len_reg == '0)
    // stopping only follows a report
    `LMRD_ASSERT_IMP(a_stop_has_peak, clk, rst_n, stopped_reg, peaks_reg != '0)
    // a fresh vector has no reports yet
    `LMRD_ASSERT_IMP(a_fresh_vector, clk, rst_n, pos_reg == '0, peaks_reg == '0)

endmodule

// ===== design/local_maxima_run_detector_top.sv =====
`timescale 1ns / 1ps
// Channel   Handshake                    Payload       Notes
// sample    sample_valid / sample_stall  sample_item   one sample per request
// peak      peak_valid / peak_stall      peak_item     zero or one per sample
// config    APB psel/penable/pwrite      paddr/pwdata  5 registers, 4-byte stride
//
// One sample per cycle sustained while peak_stall is low; a report is offered once its
// sample has passed the input register, then the result register behind the run logic.
// The run/peak update is one compare plus counter updates between the two registers.
// Reset clears all run state and loads register defaults; no clearing pass.
// A peak stall holds the result register; the input register still holds one
// sample, so sample_stall rises only when that register is full and blocked.

module local_maxima_run_detector_top
    import lmrd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_stall,
    input  lmrd_in_t    sample_item,
    output logic        peak_valid,
    input  logic        peak_stall,
    output lmrd_out_t   peak_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "local_maxima_run_detector_top_macros.svh"

    lmrd_cfg_t cfg;
    lmrd_in_t  in_item_reg;
    logic      in_valid_reg, in_valid_next;
    lmrd_out_t out_item_reg;
    logic      out_valid_reg, out_valid_next;
    lmrd_out_t result;
    logic      found;
    logic      step;
    logic      take_in;

    lmrd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lmrd_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .cfg    (cfg),
        .found  (found),
        .result (result)
    );

    // the held sample moves on when the result slot is free or being emptied
    assign step           = in_valid_reg && (!out_valid_reg || !peak_stall);
    assign sample_stall   = in_valid_reg && !step;
    assign take_in        = sample_valid && !sample_stall;
    assign in_valid_next  = take_in || (in_valid_reg && !step);
    assign out_valid_next = (step && found) || (out_valid_reg && peak_stall);
    assign peak_valid     = out_valid_reg;
    assign peak_item      = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
            in_item_reg <= sample_item;
        if (step && found)
            out_item_reg <= result;
    end

    `LMRD_ASSERT_NXT(a_report_lands, clk, rst_n, step && found, out_valid_reg)
    `LMRD_ASSERT_IMP(a_stall_needs_full, clk, rst_n, sample_stall, in_valid_reg && out_valid_reg)
    `LMRD_ASSERT_NXT(a_no_drop, clk, rst_n, out_valid_reg && peak_stall, out_valid_reg)

endmodule
